FILE: sv/assert_macros.svh
// assertion macros used by the top level rtl file
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define APU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
`define APU_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");
`else
`define APU_ASSERT(lbl, clk, rst_n, prop)
`define APU_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/apu_pkg.sv
// shared types and constants of the adam parameter update block
// no dependencies
`default_nettype none
package apu_pkg;

    localparam int MAX_VARS = 1024;
    localparam int IDX_W    = $clog2(MAX_VARS);

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    localparam logic [2:0] CFG_BETA_ONE      = 3'd0;
    localparam logic [2:0] CFG_BETA_TWO      = 3'd1;
    localparam logic [2:0] CFG_LEARNING_RATE = 3'd2;
    localparam logic [2:0] CFG_STABILIZER    = 3'd3;
    localparam logic [2:0] CFG_NUM_VARS      = 3'd4;

    typedef enum logic [1:0] {SH_0, SH_16, SH_32} t_shift;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [32:0] b;
        t_shift      sh;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_mul_rsp;

    typedef enum logic {DS_DIV, DS_SQRT} t_ds_mode;

    // for a root the radicand is {n_hi[31:0], n_lo}
    typedef struct packed {
        logic        start;
        t_ds_mode    mode;
        logic [55:0] n_hi;
        logic [31:0] n_lo;
        logic [48:0] d;
    } t_ds_req;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [31:0] q;
    } t_ds_rsp;

    typedef struct packed {
        logic [31:0] p;
        logic [39:0] m;
        logic [63:0] v;
    } t_entry;

    typedef enum logic [1:0] {MS_IDLE, MS_LO, MS_HI, MS_SUM} t_mul_state;
    typedef enum logic [1:0] {DQ_IDLE, DQ_RUN, DQ_DONE} t_ds_state;

    typedef enum logic [4:0] {
        S_IDLE, S_READ,
        S_P1, S_P1W, S_P2, S_P2W,
        S_C1, S_C1W, S_C2, S_C2W,
        S_M1, S_M1W, S_M2, S_M2W,
        S_V1, S_V1W, S_G2, S_G2W, S_V2, S_V2W,
        S_VH, S_VHW, S_SQ, S_SQW,
        S_N1, S_N1W, S_N2, S_N2W,
        S_DV, S_DVW, S_WB, S_OUT
    } t_state;

endpackage
`default_nettype wire

FILE: sv/apu_mulsh.sv
// shared 32x32 multiplier sequencer: floor(a*b / 2^sh) saturated to 64 bits
// depends on apu_pkg
`default_nettype none
module apu_mulsh (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire apu_pkg::t_mul_req i_req,
    output apu_pkg::t_mul_rsp      o_rsp
);

    apu_pkg::t_mul_state r_state, n_state;
    logic [63:0]     r_a;
    logic [32:0]     r_b;
    apu_pkg::t_shift r_sh;
    logic [63:0]     r_plo, r_phi;

    logic [31:0] op_x;
    logic [63:0] prod;
    logic [63:0] low, hs;
    logic        hovf;
    logic [64:0] sum;

    assign op_x = (r_state == apu_pkg::MS_HI) ? r_a[63:32] : r_a[31:0];
    assign prod = {32'd0, op_x} * {32'd0, r_b[31:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apu_pkg::MS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            apu_pkg::MS_IDLE: if (i_req.start) n_state = apu_pkg::MS_LO;
            apu_pkg::MS_LO:   n_state = apu_pkg::MS_HI;
            apu_pkg::MS_HI:   n_state = apu_pkg::MS_SUM;
            apu_pkg::MS_SUM:  n_state = apu_pkg::MS_IDLE;
            default:          n_state = apu_pkg::MS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == apu_pkg::MS_IDLE && i_req.start) begin
            r_a  <= i_req.a;
            r_b  <= i_req.b;
            r_sh <= i_req.sh;
        end
        if (r_state == apu_pkg::MS_LO) r_plo <= prod;
        if (r_state == apu_pkg::MS_HI) r_phi <= prod;
    end

    always_comb begin
        case (r_sh)
            apu_pkg::SH_32: begin
                low  = {32'd0, r_plo[63:32]};
                hs   = r_phi;
                hovf = 1'b0;
            end
            apu_pkg::SH_16: begin
                low  = {16'd0, r_plo[63:16]};
                hs   = {r_phi[47:0], 16'd0};
                hovf = |r_phi[63:48];
            end
            default: begin
                low  = r_plo;
                hs   = {r_phi[31:0], 32'd0};
                hovf = |r_phi[63:32];
            end
        endcase
        sum = {1'b0, hs} + {1'b0, low};
    end

    assign o_rsp.done = (r_state == apu_pkg::MS_SUM);
    // a factor of one passes the operand through
    assign o_rsp.res  = (r_sh == apu_pkg::SH_32 && r_b[32]) ? r_a :
                        (hovf || sum[64]) ? {64{1'b1}} : sum[63:0];

endmodule
`default_nettype wire

FILE: sv/apu_divsq.sv
// iterative divider and integer square root, one result bit per cycle
// depends on apu_pkg
`default_nettype none
module apu_divsq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire apu_pkg::t_ds_req i_req,
    output apu_pkg::t_ds_rsp      o_rsp
);

    apu_pkg::t_ds_state r_state, n_state;
    apu_pkg::t_ds_mode  r_mode;
    logic [48:0] r_d;
    logic [48:0] r_rem;
    logic [63:0] r_sh;
    logic [31:0] r_q;
    logic        r_ovf;
    logic [4:0]  r_cnt;

    logic        start_ovf;
    logic [49:0] div_r2, div_sub;
    logic        div_ge;
    logic [35:0] sq_r2, sq_tr, sq_sub;
    logic        sq_ge;

    // quotient would not fit in 32 bits
    assign start_ovf = (i_req.mode == apu_pkg::DS_DIV) && (i_req.n_hi >= {7'd0, i_req.d});

    assign div_r2  = {r_rem, r_sh[63]};
    assign div_ge  = div_r2 >= {1'b0, r_d};
    assign div_sub = div_r2 - {1'b0, r_d};
    assign sq_r2   = {r_rem[33:0], r_sh[63:62]};
    assign sq_tr   = {2'b00, r_q, 2'b01};
    assign sq_ge   = sq_r2 >= sq_tr;
    assign sq_sub  = sq_r2 - sq_tr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apu_pkg::DQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            apu_pkg::DQ_IDLE:
                if (i_req.start) n_state = start_ovf ? apu_pkg::DQ_DONE : apu_pkg::DQ_RUN;
            apu_pkg::DQ_RUN:
                if (r_cnt == 5'd31) n_state = apu_pkg::DQ_DONE;
            apu_pkg::DQ_DONE: n_state = apu_pkg::DQ_IDLE;
            default:          n_state = apu_pkg::DQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == apu_pkg::DQ_IDLE && i_req.start) begin
            r_mode <= i_req.mode;
            r_d    <= i_req.d;
            r_q    <= 32'd0;
            r_cnt  <= 5'd0;
            r_ovf  <= start_ovf;
            if (i_req.mode == apu_pkg::DS_DIV) begin
                r_rem <= i_req.n_hi[48:0];
                r_sh  <= {i_req.n_lo, 32'd0};
            end else begin
                r_rem <= 49'd0;
                r_sh  <= {i_req.n_hi[31:0], i_req.n_lo};
            end
        end else if (r_state == apu_pkg::DQ_RUN) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_mode == apu_pkg::DS_DIV) begin
                r_rem <= div_ge ? div_sub[48:0] : div_r2[48:0];
                r_q   <= {r_q[30:0], div_ge};
                r_sh  <= {r_sh[62:0], 1'b0};
            end else begin
                r_rem <= {15'd0, sq_ge ? sq_sub[33:0] : sq_r2[33:0]};
                r_q   <= {r_q[30:0], sq_ge};
                r_sh  <= {r_sh[61:0], 2'b00};
            end
        end
    end

    assign o_rsp.done = (r_state == apu_pkg::DQ_DONE);
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.q    = r_q;

endmodule
`default_nettype wire

FILE: sv/adam_parameter_update_top.sv
// top level of the adam parameter update block: state memory, sequencer, output register
// depends on apu_pkg, apu_mulsh, apu_divsq and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
// Adam update over up to 1024 stored Q16.16 parameters. Send a load item (tuser 0) to set a
// parameter, then gradient elements (tuser 1) in index order; index 0 begins a new step.
// One result comes back per item. A load or a rejected index goes straight to the output
// register. The 32 bit root and the divider produce one bit per cycle, every product goes
// through the one shared 32x32 multiplier, and index 0 adds two beta power products and
// two correction divides. One item is worked on at a time; the result register lets the next
// item enter while a result waits. Parameters and moments live in one 1024 entry memory
// with no clearing pass: gradients must only touch entries loaded before.
module adam_parameter_update_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,   // index[9:0], value[41:10], zeros
    input  wire logic        i_s_axis_tuser,   // kind
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata,   // result_index[9:0], param_value[41:10], zeros
    output logic             o_m_axis_tuser,   // error
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int IW = apu_pkg::IDX_W;

    apu_pkg::t_state r_state, n_state;

    logic [31:0] r_beta_one, r_beta_two, r_lr, r_stab;
    logic [10:0] r_num_vars;
    logic [32:0] r_b1p, r_b2p;
    logic [31:0] r_c1, r_c2;

    logic [IW-1:0] r_idx;
    logic [31:0]   r_g, r_p;
    logic [39:0]   r_m, r_t1;
    logic [63:0]   r_v, r_t;
    logic [48:0]   r_den;
    logic          r_err;

    logic          r_out_valid;
    logic [IW-1:0] r_out_idx;
    logic [31:0]   r_out_val;
    logic          r_out_err;

    apu_pkg::t_entry mem [apu_pkg::MAX_VARS];
    apu_pkg::t_entry r_rd, mem_wdata;
    logic            mem_we;
    logic [IW-1:0]   mem_waddr;

    apu_pkg::t_mul_req mul_req;
    apu_pkg::t_mul_rsp mul_rsp;
    apu_pkg::t_ds_req  ds_req;
    apu_pkg::t_ds_rsp  ds_rsp;

    logic          acc;
    logic [IW-1:0] in_idx;
    logic [31:0]   in_val;
    logic          in_err;
    logic [31:0]   ag;
    logic [39:0]   am, am_new;
    logic [41:0]   s1, s2, msum;
    logic [39:0]   m_sat;
    logic [64:0]   vsum;
    logic [32:0]   step;
    logic [33:0]   pn;
    logic [31:0]   p_sat;

    apu_mulsh u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mul_req), .o_rsp(mul_rsp));
    apu_divsq u_ds  (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(ds_req),  .o_rsp(ds_rsp));

    assign o_s_axis_tready = (r_state == apu_pkg::S_IDLE);
    assign acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign in_idx = i_s_axis_tdata[IW-1:0];
    assign in_val = i_s_axis_tdata[41:10];
    assign in_err = {1'b0, in_idx} >= r_num_vars;

    assign ag     = r_g[31] ? (32'd0 - r_g) : r_g;
    assign am     = r_m[39] ? (40'd0 - r_m) : r_m;
    assign am_new = am;

    // first moment: sign of m kept on beta*|m|, gradient term subtracted
    always_comb begin
        s1   = r_m[39] ? (42'd0 - {2'b00, r_t1}) : {2'b00, r_t1};
        s2   = {2'b00, mul_rsp.res[39:0]};
        msum = r_g[31] ? (s1 + s2) : (s1 - s2);
        if (!msum[41] && (msum[40:39] != 2'b00)) begin
            m_sat = {1'b0, {39{1'b1}}};
        end else if (msum[41] && (msum[40:39] != 2'b11)) begin
            m_sat = {1'b1, 39'd0};
        end else begin
            m_sat = msum[39:0];
        end
    end

    assign vsum = {1'b0, r_v} + {1'b0, mul_rsp.res};

    always_comb begin
        if (r_t == 64'd0) begin
            step = 33'd0;
        end else if (ds_rsp.ovf) begin
            step = apu_pkg::ONE_Q32;
        end else begin
            step = {1'b0, ds_rsp.q};
        end
        pn = r_m[39] ? ({{2{r_p[31]}}, r_p} + {1'b0, step})
                     : ({{2{r_p[31]}}, r_p} - {1'b0, step});
        if (!pn[33] && (pn[32:31] != 2'b00)) begin
            p_sat = 32'h7FFF_FFFF;
        end else if (pn[33] && (pn[32:31] != 2'b11)) begin
            p_sat = 32'h8000_0000;
        end else begin
            p_sat = pn[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rd <= mem[in_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mul_req   = '0;
        ds_req    = '0;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = '{p: r_p, m: r_m, v: r_v};
        unique case (r_state)
            apu_pkg::S_IDLE: begin
                mem_waddr = in_idx;
                mem_wdata = '{p: in_val, m: 40'd0, v: 64'd0};
                if (acc) begin
                    mem_we  = !i_s_axis_tuser && !in_err;
                    n_state = (in_err || !i_s_axis_tuser) ? apu_pkg::S_OUT : apu_pkg::S_READ;
                end
            end
            apu_pkg::S_READ:
                n_state = (r_idx == '0) ? apu_pkg::S_P1 : apu_pkg::S_M1;
            apu_pkg::S_P1: begin
                mul_req = '{start: 1'b1, a: {31'd0, r_b1p}, b: {1'b0, r_beta_one},
                            sh: apu_pkg::SH_32};
                n_state = apu_pkg::S_P1W;
            end
            apu_pkg::S_P1W: if (mul_rsp.done) n_state = apu_pkg::S_P2;
            apu_pkg::S_P2: begin
                mul_req = '{start: 1'b1, a: {31'd0, r_b2p}, b: {1'b0, r_beta_two},
                            sh: apu_pkg::SH_32};
                n_state = apu_pkg::S_P2W;
            end
            apu_pkg::S_P2W: if (mul_rsp.done) n_state = apu_pkg::S_C1;
            // 2^48 / (1 - power); a power of one divides by zero and saturates
            apu_pkg::S_C1: begin
                ds_req  = '{start: 1'b1, mode: apu_pkg::DS_DIV, n_hi: 56'h1_0000, n_lo: 32'd0,
                            d: {16'd0, apu_pkg::ONE_Q32 - r_b1p}};
                n_state = apu_pkg::S_C1W;
            end
            apu_pkg::S_C1W: if (ds_rsp.done) n_state = apu_pkg::S_C2;
            apu_pkg::S_C2: begin
                ds_req  = '{start: 1'b1, mode: apu_pkg::DS_DIV, n_hi: 56'h1_0000, n_lo: 32'd0,
                            d: {16'd0, apu_pkg::ONE_Q32 - r_b2p}};
                n_state = apu_pkg::S_C2W;
            end
            apu_pkg::S_C2W: if (ds_rsp.done) n_state = apu_pkg::S_M1;
            apu_pkg::S_M1: begin
                mul_req = '{start: 1'b1, a: {24'd0, am}, b: {1'b0, r_beta_one},
                            sh: apu_pkg::SH_32};
                n_state = apu_pkg::S_M1W;
            end
            apu_pkg::S_M1W: if (mul_rsp.done) n_state = apu_pkg::S_M2;
            apu_pkg::S_M2: begin
                mul_req = '{start: 1'b1, a: {24'd0, ag, 8'd0},
                            b: apu_pkg::ONE_Q32 - {1'b0, r_beta_one}, sh: apu_pkg::SH_32};
                n_state = apu_pkg::S_M2W;
            end
            apu_pkg::S_M2W: if (mul_rsp.done) n_state = apu_pkg::S_V1;
            apu_pkg::S_V1: begin
                mul_req = '{start: 1'b1, a: r_v, b: {1'b0, r_beta_two}, sh: apu_pkg::SH_32};
                n_state = apu_pkg::S_V1W;
            end
            apu_pkg::S_V1W: if (mul_rsp.done) n_state = apu_pkg::S_G2;
            apu_pkg::S_G2: begin
                mul_req = '{start: 1'b1, a: {32'd0, ag}, b: {1'b0, ag}, sh: apu_pkg::SH_0};
                n_state = apu_pkg::S_G2W;
            end
            apu_pkg::S_G2W: if (mul_rsp.done) n_state = apu_pkg::S_V2;
            apu_pkg::S_V2: begin
                mul_req = '{start: 1'b1, a: r_t, b: apu_pkg::ONE_Q32 - {1'b0, r_beta_two},
                            sh: apu_pkg::SH_32};
                n_state = apu_pkg::S_V2W;
            end
            apu_pkg::S_V2W: if (mul_rsp.done) n_state = apu_pkg::S_VH;
            apu_pkg::S_VH: begin
                mul_req = '{start: 1'b1, a: r_v, b: {1'b0, r_c2}, sh: apu_pkg::SH_16};
                n_state = apu_pkg::S_VHW;
            end
            apu_pkg::S_VHW: if (mul_rsp.done) n_state = apu_pkg::S_SQ;
            apu_pkg::S_SQ: begin
                ds_req  = '{start: 1'b1, mode: apu_pkg::DS_SQRT, n_hi: {24'd0, r_t[63:32]},
                            n_lo: r_t[31:0], d: 49'd0};
                n_state = apu_pkg::S_SQW;
            end
            apu_pkg::S_SQW: if (ds_rsp.done) n_state = apu_pkg::S_N1;
            apu_pkg::S_N1: begin
                mul_req = '{start: 1'b1, a: {24'd0, am_new}, b: {1'b0, r_c1},
                            sh: apu_pkg::SH_16};
                n_state = apu_pkg::S_N1W;
            end
            apu_pkg::S_N1W: if (mul_rsp.done) n_state = apu_pkg::S_N2;
            apu_pkg::S_N2: begin
                mul_req = '{start: 1'b1, a: r_t, b: {1'b0, r_lr}, sh: apu_pkg::SH_32};
                n_state = apu_pkg::S_N2W;
            end
            apu_pkg::S_N2W: if (mul_rsp.done) n_state = apu_pkg::S_DV;
            // step = num * 2^24 / den, capped at one
            apu_pkg::S_DV: begin
                ds_req  = '{start: 1'b1, mode: apu_pkg::DS_DIV, n_hi: r_t[63:8],
                            n_lo: {r_t[7:0], 24'd0}, d: r_den};
                n_state = apu_pkg::S_DVW;
            end
            apu_pkg::S_DVW: if (ds_rsp.done) n_state = apu_pkg::S_WB;
            apu_pkg::S_WB: begin
                mem_we  = 1'b1;
                n_state = apu_pkg::S_OUT;
            end
            apu_pkg::S_OUT:
                if (!r_out_valid || i_m_axis_tready) n_state = apu_pkg::S_IDLE;
            default: n_state = apu_pkg::S_IDLE;
        endcase
    end

    // configuration, beta powers and correction factors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta_one <= 32'd3865470566;
            r_beta_two <= 32'd4290672329;
            r_lr       <= 32'd4294967;
            r_stab     <= 32'd43;
            r_num_vars <= 11'd1024;
            r_b1p      <= apu_pkg::ONE_Q32;
            r_b2p      <= apu_pkg::ONE_Q32;
            r_c1       <= 32'd0;
            r_c2       <= 32'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    apu_pkg::CFG_BETA_ONE:      r_beta_one <= i_cfg_data;
                    apu_pkg::CFG_BETA_TWO:      r_beta_two <= i_cfg_data;
                    apu_pkg::CFG_LEARNING_RATE: r_lr       <= i_cfg_data;
                    apu_pkg::CFG_STABILIZER:    r_stab     <= i_cfg_data;
                    apu_pkg::CFG_NUM_VARS:      r_num_vars <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (acc && !i_s_axis_tuser && !in_err) begin
                r_b1p <= apu_pkg::ONE_Q32;
                r_b2p <= apu_pkg::ONE_Q32;
            end
            if (r_state == apu_pkg::S_P1W && mul_rsp.done) r_b1p <= mul_rsp.res[32:0];
            if (r_state == apu_pkg::S_P2W && mul_rsp.done) r_b2p <= mul_rsp.res[32:0];
            if (r_state == apu_pkg::S_C1W && ds_rsp.done)
                r_c1 <= ds_rsp.ovf ? 32'hFFFF_FFFF : ds_rsp.q;
            if (r_state == apu_pkg::S_C2W && ds_rsp.done)
                r_c2 <= ds_rsp.ovf ? 32'hFFFF_FFFF : ds_rsp.q;
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            apu_pkg::S_IDLE: begin
                if (acc) begin
                    r_idx <= in_idx;
                    r_g   <= in_val;
                    r_err <= in_err;
                    r_p   <= in_err ? 32'd0 : in_val;
                end
            end
            apu_pkg::S_READ: begin
                r_p <= r_rd.p;
                r_m <= r_rd.m;
                r_v <= r_rd.v;
            end
            apu_pkg::S_M1W: if (mul_rsp.done) r_t1 <= mul_rsp.res[39:0];
            apu_pkg::S_M2W: if (mul_rsp.done) r_m <= m_sat;
            apu_pkg::S_V1W: if (mul_rsp.done) r_v <= mul_rsp.res;
            apu_pkg::S_G2W: if (mul_rsp.done) r_t <= mul_rsp.res;
            apu_pkg::S_V2W: if (mul_rsp.done) r_v <= vsum[64] ? {64{1'b1}} : vsum[63:0];
            apu_pkg::S_VHW: if (mul_rsp.done) r_t <= mul_rsp.res;
            apu_pkg::S_SQW:
                if (ds_rsp.done) r_den <= {1'b0, ds_rsp.q, 16'd0} + {17'd0, r_stab};
            apu_pkg::S_N1W: if (mul_rsp.done) r_t <= mul_rsp.res;
            apu_pkg::S_N2W: if (mul_rsp.done) r_t <= mul_rsp.res;
            apu_pkg::S_DVW: if (ds_rsp.done) r_p <= p_sat;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == apu_pkg::S_OUT && (!r_out_valid || i_m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == apu_pkg::S_OUT && (!r_out_valid || i_m_axis_tready)) begin
            r_out_idx <= r_idx;
            r_out_val <= r_p;
            r_out_err <= r_err;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_val, r_out_idx};
    assign o_m_axis_tuser  = r_out_err;

    `APU_ASSERT(a_pow1_le_one, i_clk, i_rst_n, !(r_b1p[32] && (r_b1p[31:0] != 32'd0)))
    `APU_ASSERT(a_pow2_le_one, i_clk, i_rst_n, !(r_b2p[32] && (r_b2p[31:0] != 32'd0)))
    `APU_IMPLIES(a_wr_state, i_clk, i_rst_n, mem_we, (r_state == apu_pkg::S_IDLE) || (r_state == apu_pkg::S_WB))
    `APU_IMPLIES(a_err_zero, i_clk, i_rst_n, (r_state == apu_pkg::S_OUT) && r_err, r_p == 32'd0)

endmodule
`default_nettype wire

FILE: verif/adam_parameter_update_top_test.sv
// self-checking bench for the adam parameter update block: directed table, then random phases
// depends on apu_pkg and adam_parameter_update_top
`default_nettype none
module adam_parameter_update_top_test;

    localparam int  LIMIT      = 1_500_000;
    localparam int  PHASE_LEN  = 225;
    localparam bit  KIND_LOAD  = 1'b0;
    localparam bit  KIND_GRAD  = 1'b1;

    typedef struct packed {
        logic [9:0]  idx;
        logic [31:0] val;
        logic        err;
    } t_upd_res;

    typedef struct packed {
        bit          is_cfg;
        bit [2:0]    reg_sel;
        bit [31:0]   reg_val;
        bit          kind;
        bit [9:0]    idx;
        bit [31:0]   val;
        bit          chk;
        bit [31:0]   want_val;
        bit          want_err;
    } t_plan_row;

    localparam int N_PLAN = 23;
    t_plan_row plan [N_PLAN] = '{
        '{0, 0, 0, KIND_LOAD, 10'd0,    32'h0001_0000, 1, 32'h0001_0000, 0},
        '{0, 0, 0, KIND_LOAD, 10'd1,    32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 0},
        '{0, 0, 0, KIND_LOAD, 10'd1023, 32'h8000_0000, 1, 32'h8000_0000, 0},
        '{0, 0, 0, KIND_LOAD, 10'd2,    32'h0000_0000, 1, 32'h0000_0000, 0},
        // no step started yet: corrections are zero, parameter holds
        '{0, 0, 0, KIND_GRAD, 10'd1,    32'h0001_0000, 1, 32'h7FFF_FFFF, 0},
        '{0, 0, 0, KIND_GRAD, 10'd0,    32'h7FFF_FFFF, 0, 0, 0},
        '{0, 0, 0, KIND_GRAD, 10'd1,    32'h8000_0000, 0, 0, 0},
        '{0, 0, 0, KIND_GRAD, 10'd2,    32'h0000_0000, 0, 0, 0},
        '{0, 0, 0, KIND_GRAD, 10'd1023, 32'h0000_0001, 0, 0, 0},
        '{0, 0, 0, KIND_GRAD, 10'd0,    32'hFFFF_0000, 0, 0, 0},
        '{0, 0, 0, KIND_GRAD, 10'd1,    32'h0000_8000, 0, 0, 0},
        '{1, apu_pkg::CFG_BETA_ONE,   32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0},
        '{1, apu_pkg::CFG_BETA_TWO,   32'h0000_0000, 0, 0, 0, 0, 0, 0},
        '{1, apu_pkg::CFG_STABILIZER, 32'h0000_0000, 0, 0, 0, 0, 0, 0},
        // zero gradient with old moment kept: zero root, step capped at one
        '{0, 0, 0, KIND_GRAD, 10'd0,    32'h0000_0000, 0, 0, 0},
        // zero moment gives zero numerator, no change
        '{0, 0, 0, KIND_GRAD, 10'd2,    32'h0000_0000, 1, 32'h0000_0000, 0},
        '{1, apu_pkg::CFG_LEARNING_RATE, 32'h0000_0000, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, KIND_GRAD, 10'd1,    32'h1234_5678, 0, 0, 0},
        '{1, apu_pkg::CFG_NUM_VARS,   32'd4, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, KIND_GRAD, 10'd4,    32'h0000_0001, 1, 32'h0000_0000, 1},
        '{0, 0, 0, KIND_LOAD, 10'd1023, 32'h0000_0005, 1, 32'h0000_0000, 1},
        '{0, 0, 0, KIND_LOAD, 10'd3,    32'hDEAD_BEEF, 1, 32'hDEAD_BEEF, 0},
        '{0, 0, 0, KIND_GRAD, 10'd0,    32'h0000_0100, 0, 0, 0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    adam_parameter_update_top u_top (.*);

    always #4 i_clk = ~i_clk;

    // shadow of the block's registers and memory
    bit [31:0]  sh_beta_one, sh_beta_two, sh_rate, sh_eps;
    bit [10:0]  sh_num_vars;
    int         sh_param [apu_pkg::MAX_VARS];
    longint     sh_first [apu_pkg::MAX_VARS];
    bit [63:0]  sh_second [apu_pkg::MAX_VARS];
    bit [32:0]  sh_pow_one, sh_pow_two;
    bit [31:0]  sh_corr_one, sh_corr_two;
    bit         was_loaded [apu_pkg::MAX_VARS];

    t_upd_res   pending_results[$];
    int         n_fail = 0;
    int         n_results = 0;
    int         n_errs_seen = 0;
    int         cycles = 0;
    int         send_pct = 0;
    int         recv_pct = 0;

    function automatic bit [63:0] scale_floor(bit [63:0] a, bit [31:0] b, int sh);
        bit [127:0] p;
        p = ({64'b0, a} * {96'b0, b}) >> sh;
        return (p[127:64] != 0) ? '1 : p[63:0];
    endfunction

    function automatic bit [63:0] frac_scale(bit [63:0] a, bit [32:0] q);
        if (q >= apu_pkg::ONE_Q32) return a;
        return scale_floor(a, q[31:0], 32);
    endfunction

    function automatic bit [63:0] floor_root(bit [63:0] x);
        bit [63:0] res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > x) bt >>= 2;
        while (bt != 0) begin
            if (x >= res + bt) begin
                x -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic bit [31:0] bias_factor(bit [32:0] pw);
        bit [63:0] d, c;
        if (pw >= apu_pkg::ONE_Q32) return 32'hFFFF_FFFF;
        d = 64'h1_0000_0000 - pw;
        c = (64'd1 << 48) / d;
        return (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
    endfunction

    function automatic bit [63:0] step_quotient(bit [63:0] num, bit [63:0] den);
        bit [127:0] q;
        if (num == 0) return 0;
        if (den == 0) return 64'h1_0000_0000;
        if (num / den >= 256) return 64'h1_0000_0000;
        q = ({64'b0, num} << 24) / {64'b0, den};
        return q[63:0];
    endfunction

    function automatic void shadow_write(bit [2:0] sel, bit [31:0] data);
        case (sel)
            apu_pkg::CFG_BETA_ONE:      sh_beta_one = data;
            apu_pkg::CFG_BETA_TWO:      sh_beta_two = data;
            apu_pkg::CFG_LEARNING_RATE: sh_rate = data;
            apu_pkg::CFG_STABILIZER:    sh_eps = data;
            apu_pkg::CFG_NUM_VARS:      sh_num_vars = data[10:0];
            default: ;
        endcase
    endfunction

    function automatic t_upd_res predict_update(bit kind, bit [9:0] idx, bit [31:0] raw);
        t_upd_res  r;
        longint    g, m, mnew, pn;
        bit [63:0] ag, am, t, v, vh, den, num, step;
        r.idx = idx;
        r.err = 1'b0;
        if (idx >= sh_num_vars) begin
            r.val = 0;
            r.err = 1'b1;
            return r;
        end
        g = longint'(signed'(raw));
        if (kind == KIND_LOAD) begin
            sh_param[idx] = int'(raw);
            sh_first[idx] = 0;
            sh_second[idx] = 0;
            sh_pow_one = apu_pkg::ONE_Q32;
            sh_pow_two = apu_pkg::ONE_Q32;
            r.val = raw;
            return r;
        end
        ag = (g < 0) ? -g : g;
        if (idx == 0) begin
            sh_pow_one = 33'(frac_scale(64'(sh_pow_one), {1'b0, sh_beta_one}));
            sh_pow_two = 33'(frac_scale(64'(sh_pow_two), {1'b0, sh_beta_two}));
            sh_corr_one = bias_factor(sh_pow_one);
            sh_corr_two = bias_factor(sh_pow_two);
        end
        m = sh_first[idx];
        am = (m < 0) ? -m : m;
        t = frac_scale(am, {1'b0, sh_beta_one});
        mnew = (m < 0) ? -longint'(t) : longint'(t);
        t = frac_scale(ag << 8, apu_pkg::ONE_Q32 - {1'b0, sh_beta_one});
        mnew = (g < 0) ? mnew + longint'(t) : mnew - longint'(t);
        if (mnew > (64'sd1 <<< 39) - 1) mnew = (64'sd1 <<< 39) - 1;
        if (mnew < -(64'sd1 <<< 39)) mnew = -(64'sd1 <<< 39);
        sh_first[idx] = mnew;

        v = frac_scale(sh_second[idx], {1'b0, sh_beta_two});
        t = frac_scale(ag * ag, apu_pkg::ONE_Q32 - {1'b0, sh_beta_two});
        v = (v > 64'hFFFF_FFFF_FFFF_FFFF - t) ? '1 : v + t;
        sh_second[idx] = v;

        vh = scale_floor(v, sh_corr_two, 16);
        den = (floor_root(vh) << 16) + sh_eps;
        am = (mnew < 0) ? -mnew : mnew;
        num = scale_floor(am, sh_corr_one, 16);
        num = scale_floor(num, sh_rate, 32);
        step = step_quotient(num, den);

        pn = longint'(sh_param[idx]);
        pn = (mnew < 0) ? pn + longint'(step) : pn - longint'(step);
        if (pn > 64'sd2147483647) pn = 64'sd2147483647;
        if (pn < -64'sd2147483648) pn = -64'sd2147483648;
        sh_param[idx] = int'(pn);
        r.val = pn[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) i_m_axis_tready <= ($urandom_range(0, 99) >= recv_pct);

    always @(posedge i_clk) begin
        t_upd_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_results++;
            if (o_m_axis_tuser) n_errs_seen++;
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: index %0d", o_m_axis_tdata[9:0]);
                n_fail++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata[9:0] !== want.idx) begin
                    $error("result_index: expected %0d, got %0d", want.idx, o_m_axis_tdata[9:0]);
                    n_fail++;
                end
                if (o_m_axis_tdata[41:10] !== want.val) begin
                    $error("param_value: expected %h, got %h", want.val, o_m_axis_tdata[41:10]);
                    n_fail++;
                end
                if (o_m_axis_tuser !== want.err) begin
                    $error("error: expected %0d, got %0d", want.err, o_m_axis_tuser);
                    n_fail++;
                end
            end
        end
    end

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(bit [2:0] sel, bit [31:0] data);
        i_s_axis_tvalid = 1'b0;
        drain();
        i_cfg_we = 1'b1;
        i_cfg_index = sel;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        shadow_write(sel, data);
    endtask

    // one transfer on the input side; chk selects the typed expectation
    task automatic send_item(bit kind, bit [9:0] idx, bit [31:0] val,
                             bit chk, t_upd_res typed);
        t_upd_res pred;
        while ($urandom_range(0, 99) < send_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser = kind;
        i_s_axis_tdata = {6'b0, val, idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = predict_update(kind, idx, val);
        if (kind == KIND_LOAD && !pred.err) was_loaded[idx] = 1'b1;
        pending_results.push_back(chk ? typed : pred);
        @(negedge i_clk);
    endtask

    function automatic bit [31:0] rand_value();
        bit [31:0] mag;
        if ($urandom_range(0, 3) == 0) return $urandom;
        mag = $urandom >> $urandom_range(8, 31);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic bit [31:0] rand_reg(bit [31:0] dflt);
        case ($urandom_range(0, 3))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return dflt;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_upd_res  typed;
        int        n_act, cnt, stop_at;
        bit [10:0] nv;
        bit [9:0]  k;
        sh_beta_one = 32'd3865470566;
        sh_beta_two = 32'd4290672329;
        sh_rate = 32'd4294967;
        sh_eps = 32'd43;
        sh_num_vars = 11'd1024;
        sh_pow_one = apu_pkg::ONE_Q32;
        sh_pow_two = apu_pkg::ONE_Q32;
        sh_corr_one = 0;
        sh_corr_two = 0;
        foreach (was_loaded[i]) was_loaded[i] = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[r]) begin
            if (plan[r].is_cfg) begin
                write_reg(plan[r].reg_sel, plan[r].reg_val);
            end else begin
                typed = '{plan[r].idx, plan[r].want_val, plan[r].want_err};
                send_item(plan[r].kind, plan[r].idx, plan[r].val, plan[r].chk, typed);
            end
        end

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 72; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 72; end
                default: begin send_pct = 23; recv_pct = 23; end
            endcase
            if (ph == 0) begin
                write_reg(apu_pkg::CFG_BETA_ONE, 32'd3865470566);
                write_reg(apu_pkg::CFG_BETA_TWO, 32'd4290672329);
                write_reg(apu_pkg::CFG_LEARNING_RATE, 32'd4294967);
                write_reg(apu_pkg::CFG_STABILIZER, 32'd43);
            end else begin
                write_reg(apu_pkg::CFG_BETA_ONE, rand_reg(32'd3865470566));
                write_reg(apu_pkg::CFG_BETA_TWO, rand_reg(32'd4290672329));
                write_reg(apu_pkg::CFG_LEARNING_RATE, rand_reg(32'd4294967));
                write_reg(apu_pkg::CFG_STABILIZER, rand_reg(32'd43));
            end
            case (ph)
                1: nv = 11'd1;
                5: nv = 11'd1024;
                default: nv = 11'($urandom_range(2, 16));
            endcase
            write_reg(apu_pkg::CFG_NUM_VARS, 32'(nv));
            n_act = (nv == 1024) ? $urandom_range(20, 40) : $urandom_range(1, nv);
            for (int i = 0; i < n_act; i++)
                if (!was_loaded[i] || $urandom_range(0, 3) == 0)
                    send_item(KIND_LOAD, 10'(i), rand_value(), 1'b0, '0);

            cnt = 0;
            while (cnt < PHASE_LEN) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: begin
                        // a well-formed sweep, sometimes cut short
                        stop_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n_act) : n_act;
                        for (int i = 0; i < stop_at; i++)
                            send_item(KIND_GRAD, 10'(i), rand_value(), 1'b0, '0);
                        cnt += stop_at;
                    end
                    7: begin
                        send_item(KIND_LOAD, 10'($urandom_range(0, n_act - 1)), rand_value(),
                                  1'b0, '0);
                        cnt++;
                    end
                    8: begin
                        if (nv < 1024) begin
                            k = 10'($urandom_range(nv, 1023));
                            send_item(1'($urandom_range(0, 1)), k, rand_value(), 1'b0, '0);
                        end
                    end
                    default: begin
                        send_item(KIND_GRAD, 10'($urandom_range(0, n_act - 1)), rand_value(),
                                  1'b0, '0);
                        cnt++;
                    end
                endcase
                // hold off until the block has handed back everything
                if ($urandom_range(0, 39) == 0) begin
                    i_s_axis_tvalid = 1'b0;
                    while (pending_results.size() != 0) @(negedge i_clk);
                end
            end
        end

        i_s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("covered %0d results (%0d flagged out of range) over 8 register settings",
                 n_results, n_errs_seen);
        $display("with idle-free, sender-gap, receiver-stall and mixed flow phases");
        if (n_fail == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
